// ----- hw/rtl/literal_find_replace_stream_defines.svh -----
// ----------------------------------------------------------------------------
// literal find/replace stream assertion macros
// shared concurrent assertion forms, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef LITERAL_FIND_REPLACE_STREAM_DEFINES_SVH
`define LITERAL_FIND_REPLACE_STREAM_DEFINES_SVH

`ifndef ASSERT_OFF

`define LFRS_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("lfrs assertion failed");

`define LFRS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lfrs assertion failed");

`else

`define LFRS_ASSERT_ALWAYS(lbl, cond)

`define LFRS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- hw/rtl/lfrs_pkg.sv -----
// ----------------------------------------------------------------------------
// lfrs_pkg
// types, register codes and size defaults of the literal find/replace stream
// ----------------------------------------------------------------------------
package lfrs_pkg;

    localparam int PLEN_DEF  = 8;
    localparam int RLEN_DEF  = 8;
    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 4;
    localparam int REG_W     = 64;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_BYTES = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_LEN   = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              text_end;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              run_last;
    } t_out_item;

endpackage

// ----- hw/rtl/literal_find_replace_stream.sv -----
// results of an accepted transaction are registered and appear in the cycle after acceptance
// throughput: one input transaction per cycle while each yields at most one byte and the output is not stalled
// an n-byte transaction holds the input while its bytes drain, one per cycle unless stalled
// reset clears configuration, window fill and the output run; window bytes are not reset
// ----------------------------------------------------------------------------
// literal_find_replace_stream
// streaming literal find and replace with a pattern window and an output run
// buffer that, unless the receiver stalls, drains one byte per cycle
// ----------------------------------------------------------------------------
`include "literal_find_replace_stream_defines.svh"

module literal_find_replace_stream
    import lfrs_pkg::*;
#(
    parameter int PLEN = PLEN_DEF,
    parameter int RLEN = RLEN_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [REG_W-1:0]     i_cfg_data
);

    localparam int OUT_DEPTH = (PLEN > RLEN) ? PLEN : RLEN;
    localparam int FW        = $clog2(PLEN + 1);
    localparam int CW        = $clog2(OUT_DEPTH + 1);

    logic [REG_W-1:0]  r_pat_bytes;
    logic [LEN_W-1:0]  r_pat_len;
    logic [REG_W-1:0]  r_rep_bytes;
    logic [LEN_W-1:0]  r_rep_len;

    logic [BYTE_W-1:0] r_win [PLEN];
    logic [BYTE_W-1:0] n_win [PLEN];
    logic [FW-1:0]     r_fill;
    logic [FW-1:0]     n_fill;
    logic [BYTE_W-1:0] r_buf [OUT_DEPTH];
    logic [BYTE_W-1:0] n_buf [OUT_DEPTH];
    logic [CW-1:0]     r_cnt;
    logic [CW-1:0]     n_cnt;

    logic [LEN_W-1:0]  plen;
    logic [LEN_W-1:0]  rlen;
    logic [FW-1:0]     f0;
    logic [FW-1:0]     f1;
    logic [BYTE_W-1:0] w_new [PLEN];
    logic              cmp;
    logic              hit;
    logic              in_acc;
    logic              out_acc;
    logic              len_wr;

    assign plen = (r_pat_len > LEN_W'(PLEN)) ? LEN_W'(PLEN) : r_pat_len;
    assign rlen = (r_rep_len > LEN_W'(RLEN)) ? LEN_W'(RLEN) : r_rep_len;

    assign o_in_ready  = (r_cnt == '0) || ((r_cnt == CW'(1)) && i_out_ready);
    assign o_out_valid = (r_cnt != '0);
    assign o_out_data.out_byte = r_buf[0];
    assign o_out_data.run_last = (r_cnt == CW'(1));

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;
    assign len_wr  = i_cfg_we && (i_cfg_idx == REG_PATTERN_LEN);

    // window with the new byte placed at the fill position, and its compare against the pattern
    always_comb begin
        f0 = (LEN_W'(r_fill) >= plen) ? '0 : r_fill;
        f1 = f0 + FW'(1);
        for (int j = 0; j < PLEN; j++) begin
            w_new[j] = (f0 == FW'(j)) ? i_in_data.in_byte : r_win[j];
        end
        cmp = (LEN_W'(f1) == plen);
        hit = 1'b1;
        for (int j = 0; j < PLEN; j++) begin
            if ((LEN_W'(j) < plen) && (w_new[j] != r_pat_bytes[BYTE_W*j +: BYTE_W])) begin
                hit = 1'b0;
            end
        end
    end

    always_comb begin
        n_win  = r_win;
        n_fill = r_fill;
        n_buf  = r_buf;
        n_cnt  = r_cnt;
        if (out_acc) begin
            for (int j = 0; j < OUT_DEPTH - 1; j++) begin
                n_buf[j] = r_buf[j+1];
            end
            n_cnt = r_cnt - CW'(1);
        end
        if (in_acc) begin
            if (plen == '0) begin
                n_buf[0] = i_in_data.in_byte;
                n_cnt    = CW'(1);
                n_fill   = '0;
            end else if (cmp && hit) begin
                for (int j = 0; j < OUT_DEPTH; j++) begin
                    n_buf[j] = (j < RLEN) ? r_rep_bytes[BYTE_W*j +: BYTE_W] : '0;
                end
                n_cnt  = CW'(rlen);
                n_fill = '0;
            end else begin
                for (int j = 0; j < OUT_DEPTH; j++) begin
                    n_buf[j] = (j < PLEN) ? w_new[j] : '0;
                end
                if (cmp) begin
                    // no match: oldest byte leaves, window shifts down
                    for (int j = 0; j < PLEN - 1; j++) begin
                        n_win[j] = w_new[j+1];
                    end
                    n_win[PLEN-1] = w_new[PLEN-1];
                    n_cnt  = i_in_data.text_end ? CW'(plen) : CW'(1);
                    n_fill = i_in_data.text_end ? '0 : f1 - FW'(1);
                end else begin
                    n_win  = w_new;
                    n_cnt  = i_in_data.text_end ? CW'(f1) : '0;
                    n_fill = i_in_data.text_end ? '0 : f1;
                end
            end
        end
        if (len_wr) begin
            n_fill = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_cnt  <= '0;
        end else begin
            r_fill <= n_fill;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
        r_buf <= n_buf;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_bytes <= '0;
            r_pat_len   <= '0;
            r_rep_bytes <= '0;
            r_rep_len   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PATTERN_BYTES: r_pat_bytes <= i_cfg_data;
                REG_PATTERN_LEN:   r_pat_len   <= i_cfg_data[LEN_W-1:0];
                REG_REPLACE_BYTES: r_rep_bytes <= i_cfg_data;
                REG_REPLACE_LEN:   r_rep_len   <= i_cfg_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    `LFRS_ASSERT_ALWAYS(a_fill_below_plen, (r_fill == '0) || (LEN_W'(r_fill) < plen))
    `LFRS_ASSERT_ALWAYS(a_cnt_in_range, r_cnt <= CW'(OUT_DEPTH))
    `LFRS_ASSERT_NEXT(a_end_flushes, in_acc && i_in_data.text_end, r_fill == '0)
    `LFRS_ASSERT_NEXT(a_pass_single, in_acc && (plen == '0), r_cnt == CW'(1))

endmodule

// ----- tb/sv/literal_find_replace_stream_tb.sv -----
// ----------------------------------------------------------------------------
// literal_find_replace_stream_tb
// Self-checking bench for the streaming literal find and replace block.
// It drives source bytes over a valid/ready channel and predicts every
// rewritten byte with its own window and pattern state. Results are compared
// in order against the predicted queue. The bench steps through several
// pattern and replacement settings and changes idle and stall patterns on
// both sides from one phase to the next.
// ----------------------------------------------------------------------------
module literal_find_replace_stream_tb;
    import lfrs_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    class rewrite_scoreboard;
        logic [REG_W-1:0] pat_bytes;
        logic [LEN_W-1:0] pat_len;
        logic [REG_W-1:0] rep_bytes;
        logic [LEN_W-1:0] rep_len;
        logic [BYTE_W-1:0] held [PLEN_DEF];
        int unsigned held_fill;
        t_out_item rewritten_q [$];
        int errors;

        function new();
            pat_bytes = '0;
            pat_len   = '0;
            rep_bytes = '0;
            rep_len   = '0;
            held_fill = 0;
            errors    = 0;
            foreach (held[i]) held[i] = '0;
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10) $display("ERROR: %s", msg);
        endfunction

        function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
            case (idx)
                REG_PATTERN_BYTES: pat_bytes = val;
                REG_PATTERN_LEN: begin
                    pat_len   = val[LEN_W-1:0];
                    held_fill = 0;
                end
                REG_REPLACE_BYTES: rep_bytes = val;
                REG_REPLACE_LEN:   rep_len = val[LEN_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_source_byte(t_in_item it);
            int unsigned plen;
            int unsigned rlen;
            int unsigned i;
            bit hit;
            logic [BYTE_W-1:0] run [$];
            t_out_item o;
            plen = (pat_len > PLEN_DEF) ? PLEN_DEF : pat_len;
            rlen = (rep_len > RLEN_DEF) ? RLEN_DEF : rep_len;
            if (plen == 0) begin
                held_fill = 0;
                run.push_back(it.in_byte);
            end else begin
                if (held_fill >= plen) held_fill = 0;
                held[held_fill] = it.in_byte;
                held_fill++;
                if (held_fill == plen) begin
                    hit = 1'b1;
                    for (i = 0; i < plen; i++)
                        if (held[i] !== pat_bytes[8*i +: 8]) hit = 1'b0;
                    if (hit) begin
                        for (i = 0; i < rlen; i++) run.push_back(rep_bytes[8*i +: 8]);
                        held_fill = 0;
                    end else begin
                        run.push_back(held[0]);
                        for (i = 0; i + 1 < held_fill; i++) held[i] = held[i+1];
                        held_fill--;
                    end
                end
            end
            if (it.text_end) begin
                for (i = 0; i < held_fill; i++) run.push_back(held[i]);
                held_fill = 0;
            end
            for (i = 0; i < run.size(); i++) begin
                o.out_byte = run[i];
                o.run_last = (i + 1 == run.size());
                rewritten_q.push_back(o);
            end
        endfunction

        function void check_rewritten_byte(t_out_item got);
            t_out_item want;
            if (rewritten_q.size() == 0) begin
                flag($sformatf("unexpected byte %h run_last %b", got.out_byte, got.run_last));
                return;
            end
            want = rewritten_q.pop_front();
            if (got.out_byte !== want.out_byte || got.run_last !== want.run_last)
                flag($sformatf("expected byte %h run_last %b, got byte %h run_last %b",
                               want.out_byte, want.run_last, got.out_byte, got.run_last));
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    t_in_item             i_in_data;
    logic                 o_out_valid;
    logic                 i_out_ready;
    t_out_item            o_out_data;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [REG_W-1:0]     i_cfg_data;

    rewrite_scoreboard sb;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycles = 0;

    literal_find_replace_stream uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_rewritten_byte(o_out_data);
    end

    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [BYTE_W-1:0] pick_byte(logic [BYTE_W-1:0] a0,
                                                    logic [BYTE_W-1:0] a1);
        case ($urandom_range(3))
            0: return a0;
            1: return a1;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b, input bit last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid         = 1'b1;
        i_in_data.in_byte  = b;
        i_in_data.text_end = last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_source_byte(i_in_data);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.apply_reg(idx, val);
    endtask

    task automatic drain_results();
        i_in_valid = 1'b0;
        while (sb.rewritten_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin
        int p;
        int k;
        int n;
        int cut;
        int unsigned plen_eff;
        bit keep_len;
        logic [BYTE_W-1:0] a0;
        logic [BYTE_W-1:0] a1;
        logic [REG_W-1:0] pb;
        logic [REG_W-1:0] cfg;
        logic [LEN_W-1:0] new_plen;
        logic [LEN_W-1:0] new_rlen;
        logic [BYTE_W-1:0] src_bytes [$];

        sb         = new();
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // pass through after reset
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);

        drain_results();
        write_reg(REG_PATTERN_BYTES, 64'h0000_0000_00FF_0041);
        write_reg(REG_PATTERN_LEN, 64'd3);
        write_reg(REG_REPLACE_BYTES, 64'h8877_6655_4433_2211);
        write_reg(REG_REPLACE_LEN, 64'd8);
        send_byte(8'h41, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        // overlapping prefix shifts out
        send_byte(8'h41, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h41, 1'b1);

        // empty replacement
        drain_results();
        write_reg(REG_REPLACE_LEN, 64'd0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);

        // oversized lengths clamp to full width
        drain_results();
        write_reg(REG_PATTERN_BYTES, 64'h0102_0304_0506_0708);
        write_reg(REG_PATTERN_LEN, 64'd15);
        write_reg(REG_REPLACE_BYTES, 64'hFF00_FF00_A55A_C33C);
        write_reg(REG_REPLACE_LEN, 64'd15);
        for (k = 0; k < 8; k++) send_byte(8'(8 - k), 1'b0);

        // pattern length rewrite drops the held prefix
        send_byte(8'h08, 1'b0);
        send_byte(8'h07, 1'b0);
        drain_results();
        write_reg(REG_PATTERN_LEN, 64'd8);
        send_byte(8'h06, 1'b1);

        for (p = 0; p < 8; p++) begin
            drain_results();
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            keep_len = (p == 1 || p == 3 || p == 7);
            case (p)
                0: begin new_plen = 4'd1;  new_rlen = 4'd8;  end
                1: begin new_plen = 4'd1;  new_rlen = 4'd15; end
                2: begin new_plen = 4'd8;  new_rlen = 4'd1;  end
                3: begin new_plen = 4'd8;  new_rlen = 4'd0;  end
                4: begin new_plen = 4'd0;  new_rlen = 4'($urandom_range(15)); end
                5: begin new_plen = 4'd15; new_rlen = 4'($urandom_range(15)); end
                default: begin
                    new_plen = 4'($urandom_range(7, 2));
                    new_rlen = 4'($urandom_range(15));
                end
            endcase
            a0 = 8'($urandom_range(255));
            a1 = 8'($urandom_range(255));
            for (k = 0; k < 8; k++) pb[8*k +: 8] = pick_byte(a0, a1);

            // pattern bytes may change while a prefix is held
            write_reg(REG_PATTERN_BYTES, pb);
            if (!keep_len) begin
                cfg      = {$urandom, $urandom};
                cfg[3:0] = new_plen;
                write_reg(REG_PATTERN_LEN, cfg);
            end
            write_reg(REG_REPLACE_BYTES, {$urandom, $urandom});
            cfg      = {$urandom, $urandom};
            cfg[3:0] = new_rlen;
            write_reg(REG_REPLACE_LEN, cfg);

            plen_eff = (sb.pat_len > PLEN_DEF) ? PLEN_DEF : sb.pat_len;
            src_bytes.delete();
            while (src_bytes.size() < 10) begin
                n = $urandom_range(9);
                if (n < 4 && plen_eff > 0) begin
                    for (k = 0; k < plen_eff; k++) src_bytes.push_back(pb[8*k +: 8]);
                end else if (n < 6 && plen_eff > 1) begin
                    cut = $urandom_range(plen_eff - 1, 1);
                    for (k = 0; k < cut; k++) src_bytes.push_back(pb[8*k +: 8]);
                end else if (n < 8) begin
                    src_bytes.push_back(pick_byte(a0, a1));
                end else begin
                    src_bytes.push_back(8'($urandom_range(255)));
                end
            end

            for (k = 0; k < src_bytes.size(); k++) begin
                send_byte(src_bytes[k], ($urandom_range(11) == 0) ||
                          (k == src_bytes.size() - 1 && p % 3 == 0));
                if (p == 5 && k == src_bytes.size() / 2) drain_results();
            end
        end

        drain_results();
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/lfrs_pkg.sv
hw/rtl/literal_find_replace_stream.sv
tb/sv/literal_find_replace_stream_tb.sv
